// File: design/bdod_pkg.sv
package bdod_pkg;

    localparam int PROB_W  = 32;
    localparam int RATE_W  = 32;
    localparam int SUM_W   = 34;
    localparam int K_W     = 6;
    localparam int COEF_W  = SUM_W + K_W;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 96;
    localparam int DER_W   = 64;
    localparam int HL_W    = 6;
    localparam int CIDX_W  = 3;

    localparam logic [CIDX_W-1:0] CFG_GOOD_SPEC = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_INC_SPEC  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_GOOD_EXT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_INC_EXT   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_COMPL     = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_HALF      = 3'd5;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // one good entry and one incipient entry
    typedef struct packed {
        logic [PROB_W-1:0] g;
        logic [PROB_W-1:0] h;
    } cell_data_t;

    typedef enum logic [1:0] {
        SUB_LATCH  = 2'd0,
        SUB_MUL_LO = 2'd1,
        SUB_ADD_LO = 2'd2,
        SUB_ADD_HI = 2'd3
    } sub_t;

    typedef struct packed {
        logic clear;
        logic run;
        sub_t sub;
    } mac_ctrl_t;

endpackage

// File: design/bdod_cell.sv
module bdod_cell (
    input  logic                   clk,
    input  logic                   shift_fwd,
    input  logic                   shift_back,
    input  bdod_pkg::cell_data_t   from_next,
    input  bdod_pkg::cell_data_t   from_prev,
    input  logic                   wr_g,
    input  logic                   wr_h,
    input  logic [31:0]            wr_data,
    output bdod_pkg::cell_data_t   data
);
    import bdod_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (shift_fwd)
        begin
            data_next = from_next;
        end
        else if (shift_back)
        begin
            data_next = from_prev;
        end
        else
        begin
            if (wr_g)
            begin
                data_next.g = wr_data;
            end
            if (wr_h)
            begin
                data_next.h = wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: design/bdod_mac.sv
module bdod_mac (
    input  logic                        clk,
    input  bdod_pkg::mac_ctrl_t         ctrl,
    input  logic [bdod_pkg::COEF_W-1:0] coef,
    input  logic [bdod_pkg::PROB_W-1:0] prob,
    input  logic                        neg,
    output logic [bdod_pkg::DER_W-1:0]  result
);
    import bdod_pkg::*;

    logic [COEF_W-1:0] coef_reg;
    logic [PROB_W-1:0] prob_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  term;
    logic [ACC_W-80:0] top_bits;

    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        term      = '0;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.run)
        begin
            unique case (ctrl.sub)
                SUB_LATCH:
                begin
                    prod_next = prod_reg;
                end
                SUB_MUL_LO:
                begin
                    prod_next = coef_reg[31:0] * prob_reg;
                end
                SUB_ADD_LO:
                begin
                    term      = {32'd0, prod_reg};
                    acc_next  = neg_reg ? acc_reg - term : acc_reg + term;
                    prod_next = PROD_W'(coef_reg[COEF_W-1:32]) * PROD_W'(prob_reg);
                end
                SUB_ADD_HI:
                begin
                    term     = {prod_reg, 32'd0};
                    acc_next = neg_reg ? acc_reg - term : acc_reg + term;
                end
                default:
                begin
                    prod_next = prod_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run && ctrl.sub == SUB_LATCH)
        begin
            coef_reg <= coef;
            prob_reg <= prob;
            neg_reg  <= neg;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // floor to q.32, saturate to 64 bits
    assign top_bits = acc_reg[ACC_W-1:79];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            result = acc_reg[79:16];
        end
        else if (acc_reg[ACC_W-1])
        begin
            result = {1'b1, {(DER_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(DER_W-1){1'b1}}};
        end
    end

endmodule

// File: design/birth_death_ode_derivative.sv
// load transaction: taken whenever the block is idle
// compute transaction: one mac pass per term slot, 4 slots per equation; each pass steps
//   through latch, low multiply, low add and high add, with ring rotation and output on top
// throughput: one item at a time; stall stays high until a compute run ends
// reset: rates clear to 0, half length to 32, load pointer to 0, no result pending
// vector entries are not reset
module birth_death_ode_derivative #(
    parameter int MAX_HALF = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        action,
    input  logic [31:0] value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] derivative,
    output logic        last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bdod_pkg::*;

    localparam int HALF_W = $clog2(MAX_HALF + 1);
    localparam int IDX_W  = (MAX_HALF > 2) ? $clog2(MAX_HALF) : 1;
    localparam int PTR_W  = $clog2(2 * MAX_HALF + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEEK = 4'b0010,
        ST_CALC = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // which equation the sequencer is working on, or the final ring restore
    typedef enum logic [5:0] {
        PH_G0A     = 6'b000001,
        PH_G0S     = 6'b000010,
        PH_G       = 6'b000100,
        PH_H       = 6'b001000,
        PH_HM      = 6'b010000,
        PH_RESTORE = 6'b100000
    } phase_t;

    // configuration registers
    logic [RATE_W-1:0] bg_reg, bi_reg, mg_reg, mi_reg, la_reg;
    logic [HL_W-1:0]   half_reg;

    // sequencer state
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [HALF_W-1:0] i_reg, i_next;
    logic [HALF_W-1:0] rot_reg, rot_next;
    logic [HALF_W-1:0] target_reg, target_next;
    logic [1:0]        slot_reg, slot_next;
    sub_t              sub_reg, sub_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DER_W-1:0]  der_reg, der_next;
    logic              last_reg, last_next;

    logic [HALF_W-1:0] m_val;
    logic [PTR_W-1:0]  m_ptr;
    logic              load_acc, comp_acc, out_free;
    logic              shift_fwd, shift_back;
    logic              wr_g_en, wr_h_en;
    logic [IDX_W-1:0]  wr_addr;
    cell_data_t        ring [MAX_HALF];
    cell_data_t        prev_e, cur_e, nxt_e;

    // term selection
    logic [SUM_W-1:0]  s_mila, s_mibila, s_mgbg;
    logic [SUM_W-1:0]  rate_sel, addend;
    logic [K_W-1:0]    k_sel, i_k, im1_k, ip1_k;
    logic [COEF_W-1:0] small_prod, coef;
    logic [PROB_W-1:0] prob_sel;
    logic              term_en, term_neg;
    logic [DER_W-1:0]  mac_result;
    mac_ctrl_t         mac_ctrl;

    assign cfg_ready = 1'b1;

    // effective half length, clamped to 2..MAX_HALF
    always_comb
    begin
        priority if (half_reg < HL_W'(2))
        begin
            m_val = HALF_W'(2);
        end
        else if (half_reg > HL_W'(MAX_HALF))
        begin
            m_val = HALF_W'(MAX_HALF);
        end
        else
        begin
            m_val = HALF_W'(half_reg);
        end
    end

    assign m_ptr = PTR_W'(m_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg   <= '0;
            bi_reg   <= '0;
            mg_reg   <= '0;
            mi_reg   <= '0;
            la_reg   <= '0;
            half_reg <= HL_W'(32);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GOOD_SPEC: bg_reg   <= cfg_data;
                CFG_INC_SPEC:  bi_reg   <= cfg_data;
                CFG_GOOD_EXT:  mg_reg   <= cfg_data;
                CFG_INC_EXT:   mi_reg   <= cfg_data;
                CFG_COMPL:     la_reg   <= cfg_data;
                CFG_HALF:      half_reg <= cfg_data[HL_W-1:0];
                default:       half_reg <= half_reg;
            endcase
        end
    end

    // handshake
    assign item_stall = (state_reg != ST_IDLE);
    assign load_acc   = item_valid && !item_stall && (action == ACT_LOAD);
    assign comp_acc   = item_valid && !item_stall && (action == ACT_COMPUTE);
    assign out_free   = !out_valid_reg || !result_stall;

    // load addressing: good half first, then incipient half
    always_comb
    begin
        wr_g_en = 1'b0;
        wr_h_en = 1'b0;
        wr_addr = IDX_W'(ptr_reg);
        ptr_next = ptr_reg;
        if (load_acc)
        begin
            if (ptr_reg < m_ptr)
            begin
                wr_g_en  = 1'b1;
                wr_addr  = IDX_W'(ptr_reg);
                ptr_next = ptr_reg + PTR_W'(1);
            end
            else if (ptr_reg < (m_ptr << 1))
            begin
                wr_h_en  = 1'b1;
                wr_addr  = IDX_W'(ptr_reg - m_ptr);
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end
        else if (comp_acc)
        begin
            ptr_next = '0;
        end
    end

    // ring rotation: cell 0 holds entry rot_reg, its neighbors hold rot_reg -/+ 1
    assign shift_fwd  = (state_reg == ST_SEEK) && (rot_reg < target_reg);
    assign shift_back = (state_reg == ST_SEEK) && (rot_reg > target_reg);

    for (genvar c = 0; c < MAX_HALF; c++)
    begin : g_cell
        bdod_cell u_cell (
            .clk        (clk),
            .shift_fwd  (shift_fwd),
            .shift_back (shift_back),
            .from_next  (ring[(c + 1) % MAX_HALF]),
            .from_prev  (ring[(c + MAX_HALF - 1) % MAX_HALF]),
            .wr_g       (wr_g_en && (wr_addr == IDX_W'(c))),
            .wr_h       (wr_h_en && (wr_addr == IDX_W'(c))),
            .wr_data    (value),
            .data       (ring[c])
        );
    end

    assign prev_e = ring[MAX_HALF-1];
    assign cur_e  = ring[0];
    assign nxt_e  = ring[1];

    // rate sums
    assign s_mila   = SUM_W'(mi_reg) + SUM_W'(la_reg);
    assign s_mibila = SUM_W'(mi_reg) + SUM_W'(bi_reg) + SUM_W'(la_reg);
    assign s_mgbg   = SUM_W'(mg_reg) + SUM_W'(bg_reg);
    assign i_k      = K_W'(i_reg);
    assign im1_k    = i_k - K_W'(1);
    assign ip1_k    = i_k + K_W'(1);

    // term table: coef = rate * k + addend, applied to one window entry
    always_comb
    begin
        rate_sel = '0;
        k_sel    = '0;
        addend   = '0;
        prob_sel = '0;
        term_en  = 1'b0;
        term_neg = 1'b0;
        unique case (phase_reg)
            PH_G0A:
            begin
                unique case (slot_reg)
                    2'd0:
                    begin
                        term_en = 1'b1; rate_sel = s_mila; k_sel = K_W'(1);
                        prob_sel = nxt_e.g;
                    end
                    2'd1:
                    begin
                        term_en = 1'b1; term_neg = 1'b1; rate_sel = s_mgbg;
                        k_sel = K_W'(1); prob_sel = cur_e.g;
                    end
                    default:
                    begin
                        term_en = 1'b0;
                    end
                endcase
            end
            PH_G0S:
            begin
                unique case (slot_reg)
                    2'd0:
                    begin
                        term_en = 1'b1; rate_sel = SUM_W'(la_reg); k_sel = i_k;
                        prob_sel = cur_e.g;
                    end
                    2'd1:
                    begin
                        term_en = 1'b1; rate_sel = SUM_W'(la_reg); k_sel = i_k;
                        prob_sel = prev_e.h;
                    end
                    default:
                    begin
                        term_en = 1'b0;
                    end
                endcase
            end
            PH_G:
            begin
                unique case (slot_reg)
                    2'd0:
                    begin
                        term_en = 1'b1; rate_sel = SUM_W'(bi_reg); k_sel = im1_k;
                        addend = SUM_W'(bg_reg); prob_sel = prev_e.g;
                    end
                    2'd1:
                    begin
                        // upper neighbor is cut at the edge
                        term_en = (i_reg + HALF_W'(1)) < m_val;
                        rate_sel = s_mila; k_sel = ip1_k; prob_sel = nxt_e.g;
                    end
                    2'd2:
                    begin
                        term_en = 1'b1; term_neg = 1'b1; rate_sel = s_mibila;
                        k_sel = i_k; addend = s_mgbg; prob_sel = cur_e.g;
                    end
                    default:
                    begin
                        term_en = 1'b0;
                    end
                endcase
            end
            PH_H:
            begin
                unique case (slot_reg)
                    2'd0:
                    begin
                        // lower neighbor absent for h1
                        term_en = (i_reg > HALF_W'(1));
                        rate_sel = SUM_W'(bi_reg); k_sel = im1_k; prob_sel = prev_e.h;
                    end
                    2'd1:
                    begin
                        term_en = 1'b1; rate_sel = s_mila; k_sel = ip1_k;
                        prob_sel = nxt_e.h;
                    end
                    2'd2:
                    begin
                        term_en = 1'b1; term_neg = 1'b1; rate_sel = s_mibila;
                        k_sel = i_k; prob_sel = cur_e.h;
                    end
                    default:
                    begin
                        term_en = 1'b1; rate_sel = SUM_W'(mg_reg); k_sel = K_W'(1);
                        prob_sel = nxt_e.g;
                    end
                endcase
            end
            default:
            begin
                term_en = 1'b0;
            end
        endcase
    end

    assign small_prod = rate_sel * k_sel;
    assign coef       = term_en ? (small_prod + COEF_W'(addend)) : '0;

    assign mac_ctrl.run   = (state_reg == ST_CALC);
    assign mac_ctrl.sub   = sub_reg;
    assign mac_ctrl.clear = comp_acc || ((state_reg == ST_EMIT) && out_free);

    bdod_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .coef   (coef),
        .prob   (prob_sel),
        .neg    (term_neg),
        .result (mac_result)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        i_next         = i_reg;
        rot_next       = rot_reg;
        target_next    = target_reg;
        slot_next      = slot_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        der_next       = der_reg;
        last_next      = last_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (comp_acc)
                begin
                    phase_next  = PH_G0A;
                    i_next      = HALF_W'(1);
                    target_next = '0;
                    state_next  = ST_SEEK;
                end
            end
            ST_SEEK:
            begin
                if (shift_fwd)
                begin
                    rot_next = rot_reg + HALF_W'(1);
                end
                else if (shift_back)
                begin
                    rot_next = rot_reg - HALF_W'(1);
                end
                else if (phase_reg == PH_RESTORE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CALC;
                    slot_next  = '0;
                    sub_next   = SUB_LATCH;
                end
            end
            ST_CALC:
            begin
                sub_next = sub_t'(sub_reg + 2'd1);
                if (sub_reg == SUB_ADD_HI)
                begin
                    slot_next = slot_reg + 2'd1;
                    if (slot_reg == 2'd3)
                    begin
                        unique case (phase_reg)
                            PH_G0A:
                            begin
                                phase_next  = PH_G0S;
                                i_next      = HALF_W'(1);
                                target_next = HALF_W'(1);
                                state_next  = ST_SEEK;
                            end
                            PH_G0S:
                            begin
                                if (i_reg == m_val - HALF_W'(1))
                                begin
                                    state_next = ST_EMIT;
                                end
                                else
                                begin
                                    i_next      = i_reg + HALF_W'(1);
                                    target_next = i_reg + HALF_W'(1);
                                    state_next  = ST_SEEK;
                                end
                            end
                            default:
                            begin
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    der_next       = (phase_reg == PH_HM) ? '0 : mac_result;
                    last_next      = (phase_reg == PH_HM);
                    unique case (phase_reg)
                        PH_G0S:
                        begin
                            phase_next  = PH_G;
                            i_next      = HALF_W'(1);
                            target_next = HALF_W'(1);
                            state_next  = ST_SEEK;
                        end
                        PH_G:
                        begin
                            if (i_reg == m_val - HALF_W'(1))
                            begin
                                phase_next  = PH_H;
                                i_next      = HALF_W'(1);
                                target_next = '0;
                            end
                            else
                            begin
                                i_next      = i_reg + HALF_W'(1);
                                target_next = i_reg + HALF_W'(1);
                            end
                            state_next = ST_SEEK;
                        end
                        PH_H:
                        begin
                            if (i_reg == m_val - HALF_W'(1))
                            begin
                                // hM derivative is a constant zero
                                phase_next = PH_HM;
                            end
                            else
                            begin
                                i_next      = i_reg + HALF_W'(1);
                                target_next = i_reg;
                                state_next  = ST_SEEK;
                            end
                        end
                        default:
                        begin
                            // bring the ring back to its home position
                            phase_next  = PH_RESTORE;
                            target_next = '0;
                            state_next  = ST_SEEK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_RESTORE;
            i_reg         <= HALF_W'(1);
            rot_reg       <= '0;
            target_reg    <= '0;
            slot_reg      <= '0;
            sub_reg       <= SUB_LATCH;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            i_reg         <= i_next;
            rot_reg       <= rot_next;
            target_reg    <= target_next;
            slot_reg      <= slot_next;
            sub_reg       <= sub_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        der_reg  <= der_next;
        last_reg <= last_next;
    end

    assign result_valid = out_valid_reg;
    assign derivative   = der_reg;
    assign last_result  = last_reg;

`ifndef SYNTH
    a_home_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (rot_reg == '0))
        else $error("ring not at home position while idle");

    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (der_reg == '0))
        else $error("final derivative of a run is not zero");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> ((i_reg >= HALF_W'(1)) && (i_reg < m_val)))
        else $error("entry index out of range during calculation");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(2 * MAX_HALF))
        else $error("load pointer beyond vector length");
`endif

endmodule
